// File: sv/fbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_pkg
// Shared types and constants of the FFT bin sideband demodulator.
// ----------------------------------------------------------------------------
package fbsd_pkg;

    localparam int MAX_BINS  = 1024;
    localparam int ADDR_W    = $clog2(MAX_BINS);
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 18;
    localparam int LEN_W     = 11;
    localparam int CORNER_W  = 18;
    localparam int OFF_W     = 12;
    localparam int POS_W     = 13;
    localparam int FAC_W     = 20;
    localparam int DEN_W     = 2 * FAC_W;
    localparam int NUM_W     = 20;
    localparam int Q_W       = 18;
    localparam int MAG_W     = SAMPLE_W + 1;
    localparam int PROD_W    = MAG_W + Q_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_USB  = 2'd1,
        MODE_LSB  = 2'd2,
        MODE_ZERO = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_BIN_OFFSET  = 3'd1,
        REG_OUT_LENGTH  = 3'd2,
        REG_IN_LENGTH   = 3'd3,
        REG_LOW_CORNER  = 3'd4,
        REG_HIGH_CORNER = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic                       opcode;
        logic [ADDR_W-1:0]          bin_index;
        logic signed [SAMPLE_W-1:0] bin_re;
        logic signed [SAMPLE_W-1:0] bin_im;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]          out_index;
        logic signed [SAMPLE_W-1:0] out_re;
        logic signed [SAMPLE_W-1:0] out_im;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0]          idx;
        logic                       zero;
        logic                       raw;
        logic                       conj;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } t_side;

endpackage

// File: sv/fbsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/fbsd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_div
// Pipelined restoring divider: rounded bandpass weight, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module fbsd_div
    import fbsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_vld,
    output t_side            o_side,
    output logic [Q_W-1:0]   o_quot
);

    localparam int N_W = NUM_W + 33;

    logic             r_vld  [Q_W+1];
    t_side            r_side [Q_W+1];
    logic [DEN_W-1:0] r_den  [Q_W+1];
    logic [DEN_W-1:0] r_rem  [Q_W+1];
    logic [Q_W-1:0]   r_low  [Q_W+1];
    logic [Q_W-1:0]   r_q    [Q_W+1];

    logic [N_W-1:0]   c_n;

    assign c_n = {i_num, 33'd0} + N_W'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            r_rem[0]  <= DEN_W'(c_n[N_W-1:Q_W]);
            r_low[0]  <= c_n[Q_W-1:0];
            r_q[0]    <= '0;
        end
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_step
        logic [DEN_W:0] c_t;
        logic           c_ge;
        logic [DEN_W:0] c_diff;

        assign c_t    = {r_rem[s], r_low[s][Q_W-1]};
        assign c_ge   = c_t >= {1'b0, r_den[s]};
        assign c_diff = c_t - {1'b0, r_den[s]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_den[s+1]  <= r_den[s];
                r_rem[s+1]  <= c_ge ? c_diff[DEN_W-1:0] : c_t[DEN_W-1:0];
                r_low[s+1]  <= {r_low[s][Q_W-2:0], 1'b0};
                r_q[s+1]    <= {r_q[s][Q_W-2:0], c_ge};
            end
        end
    end

    assign o_vld  = r_vld[Q_W];
    assign o_side = r_side[Q_W];
    assign o_quot = r_q[Q_W];

endmodule

// File: sv/fbsd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsd_scale
// Weight multiply, round, saturate, conjugate and output register, with zero and raw bypass.
// ----------------------------------------------------------------------------
module fbsd_scale
    import fbsd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  t_side          i_side,
    input  logic [Q_W-1:0] i_quot,
    output logic           o_vld,
    output t_out_item      o_item
);

    localparam int RND_W = PROD_W - 16 + 1;

    logic              r_vld;
    t_side             r_side;
    logic [PROD_W-1:0] r_p_re;
    logic [PROD_W-1:0] r_p_im;
    logic              r_out_vld;
    t_out_item         r_out;

    logic [MAG_W-1:0]  c_mag_re;
    logic [MAG_W-1:0]  c_mag_im;
    logic signed [SAMPLE_W-1:0] c_re;
    logic signed [SAMPLE_W-1:0] c_im;
    logic signed [SAMPLE_W-1:0] c_im_c;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic [PROD_W-1:0] p,
        input logic              neg
    );
        logic [RND_W-1:0] q;
        logic [RND_W-1:0] lim;
        q = RND_W'(({1'b0, p} + (PROD_W+1)'(32768)) >> 16);
        lim = neg ? RND_W'(32768) : RND_W'(32767);
        if (q > lim) begin
            q = lim;
        end
        round_sat = neg ? -SAMPLE_W'(q) : SAMPLE_W'(q);
    endfunction

    assign c_mag_re = i_side.re[SAMPLE_W-1] ? -{i_side.re[SAMPLE_W-1], i_side.re}
                                            : {1'b0, i_side.re};
    assign c_mag_im = i_side.im[SAMPLE_W-1] ? -{i_side.im[SAMPLE_W-1], i_side.im}
                                            : {1'b0, i_side.im};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= i_vld;
            r_out_vld <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_p_re <= PROD_W'(c_mag_re) * PROD_W'(i_quot);
            r_p_im <= PROD_W'(c_mag_im) * PROD_W'(i_quot);
        end
    end

    always_comb begin
        c_re   = round_sat(r_p_re, r_side.re[SAMPLE_W-1]);
        c_im   = round_sat(r_p_im, r_side.im[SAMPLE_W-1]);
        c_im_c = c_im;
        if (r_side.conj) begin
            c_im_c = (c_im == {1'b1, {(SAMPLE_W-1){1'b0}}}) ? {1'b0, {(SAMPLE_W-1){1'b1}}}
                                                           : -c_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.out_index <= r_side.idx;
            if (r_side.zero) begin
                r_out.out_re <= '0;
                r_out.out_im <= '0;
            end else if (r_side.raw) begin
                r_out.out_re <= r_side.re;
                r_out.out_im <= r_side.im;
            end else begin
                r_out.out_re <= c_re;
                r_out.out_im <= c_im_c;
            end
        end
    end

    assign o_vld  = r_out_vld;
    assign o_item = r_out;

endmodule

// File: sv/fft_bin_sideband_demod_top.sv
`timescale 1ns / 1ps
// A read transfer passes the decode and store read registers, the weight divider
// and the scaling registers before it gives its result.
// Throughput: one transfer per cycle; a stalled output freezes the whole pipeline.
// Writes give no result and update the bin store at acceptance.
// Reset: synchronous active low; clears pipeline valids and sets config registers
// to their defaults, the bin store is undefined until written.
// ----------------------------------------------------------------------------
// fft_bin_sideband_demod_top
// Frequency-domain SSB demodulator: bin store, address decode, weight
// divider and scaling pipeline.
// ----------------------------------------------------------------------------
module fft_bin_sideband_demod_top
    import fbsd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_mode                   r_mode;
    logic signed [OFF_W-1:0] r_off;
    logic [LEN_W-1:0]        r_out_len;
    logic [LEN_W-1:0]        r_in_len;
    logic [CORNER_W-1:0]     r_low_c;
    logic [CORNER_W-1:0]     r_high_c;

    logic c_en;
    logic c_acc;

    logic [ADDR_W-1:0]       c_k;
    logic [ADDR_W-1:0]       c_len;
    logic [ADDR_W-1:0]       c_half;
    logic [LEN_W-1:0]        c_two_len;
    logic signed [POS_W-1:0] c_off;
    logic signed [POS_W-1:0] c_ks;
    logic                    c_lt;
    logic                    c_raw_in;
    logic                    c_w_in;
    logic                    c_mirror;
    logic [ADDR_W-1:0]       c_i;
    logic signed [POS_W-1:0] c_is;
    logic signed [POS_W-1:0] c_j_raw;
    logic signed [POS_W-1:0] c_j_w;
    logic signed [POS_W-1:0] c_j;
    logic signed [POS_W-1:0] c_hs;
    logic signed [POS_W-1:0] c_idx;
    logic                    c_ok;
    logic                    c_zero;
    logic                    c_raw;

    logic                    r1_vld;
    logic [ADDR_W-1:0]       r1_k;
    logic                    r1_zero;
    logic                    r1_raw;
    logic                    r1_conj;
    logic [ADDR_W-1:0]       r1_i;
    logic [ADDR_W-1:0]       r1_len;
    logic [2*SAMPLE_W-1:0]   c_rd;

    logic [ADDR_W-1:0]       c_li;
    logic [FAC_W-1:0]        c_d1;
    logic [FAC_W-1:0]        c_d2;
    logic                    r2_vld;
    t_side                   r2_side;
    logic [DEN_W-1:0]        r2_den;
    logic [NUM_W-1:0]        r2_num;

    logic                    c_div_vld;
    t_side                   c_div_side;
    logic [Q_W-1:0]          c_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_USB;
            r_off     <= '0;
            r_out_len <= LEN_W'(MAX_BINS);
            r_in_len  <= LEN_W'(MAX_BINS);
            r_low_c   <= '0;
            r_high_c  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:        r_mode    <= t_mode'(i_cfg_wdata[1:0]);
                REG_BIN_OFFSET:  r_off     <= i_cfg_wdata[OFF_W-1:0];
                REG_OUT_LENGTH:  r_out_len <= i_cfg_wdata[LEN_W-1:0];
                REG_IN_LENGTH:   r_in_len  <= i_cfg_wdata[LEN_W-1:0];
                REG_LOW_CORNER:  r_low_c   <= i_cfg_wdata[CORNER_W-1:0];
                REG_HIGH_CORNER: r_high_c  <= i_cfg_wdata[CORNER_W-1:0];
                default: ;
            endcase
        end
    end

    assign c_en    = !o_valid || i_ready;
    assign o_ready = c_en;
    assign c_acc   = i_valid && c_en;

    always_comb begin
        c_k       = i_item.bin_index;
        c_len     = r_out_len[LEN_W-1:1];
        c_half    = r_in_len[LEN_W-1:1];
        c_two_len = {c_len, 1'b0};
        c_off     = {r_off[OFF_W-1], r_off};
        c_ks      = $signed({3'b000, c_k});
        c_lt      = c_k < c_len;
        c_raw_in  = c_lt || ({1'b0, c_k} >= (r_out_len - {1'b0, c_len})
                             && {1'b0, c_k} < r_out_len);
        c_j_raw   = c_ks + c_off - (c_lt ? '0 : $signed({2'b00, r_out_len}));
        c_mirror  = c_k > c_len;
        c_i       = c_mirror ? ADDR_W'(c_two_len - {1'b0, c_k}) : c_k;
        c_is      = $signed({3'b000, c_i});
        c_w_in    = (c_k != '0) && (c_k != c_len) && ({1'b0, c_k} < c_two_len);
        c_j_w     = (r_mode == MODE_USB) ? c_off + c_is : c_off - c_is;
        c_raw     = r_mode == MODE_RAW;
        c_j       = c_raw ? c_j_raw : c_j_w;
        c_hs      = $signed({3'b000, c_half});
        c_ok      = (c_j >= -c_hs) && (c_j < c_hs);
        c_idx     = c_j[POS_W-1] ? c_j + $signed({2'b00, r_in_len}) : c_j;
        c_zero    = (r_mode == MODE_ZERO) || (c_raw ? !c_raw_in : !c_w_in) || !c_ok
                    || (c_idx[POS_W-1:ADDR_W] != '0);
    end

    fbsd_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (MAX_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (c_acc && i_item.opcode == OP_WRITE),
        .i_waddr (i_item.bin_index),
        .i_wdata ({i_item.bin_re, i_item.bin_im}),
        .i_re    (c_en),
        .i_raddr (c_idx[ADDR_W-1:0]),
        .o_rdata (c_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (c_en) begin
            r1_vld <= c_acc && i_item.opcode == OP_READ;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r1_k    <= c_k;
            r1_zero <= c_zero;
            r1_raw  <= c_raw;
            r1_conj <= c_mirror == (r_mode == MODE_USB);
            r1_i    <= c_i;
            r1_len  <= c_len;
        end
    end

    assign c_li = r1_len - r1_i;
    assign c_d1 = FAC_W'(r_low_c) + {2'b00, r1_i, 8'd0};
    assign c_d2 = FAC_W'(r_high_c) + {2'b00, c_li, 8'd0};

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r2_side.idx  <= r1_k;
            r2_side.zero <= r1_zero;
            r2_side.raw  <= r1_raw;
            r2_side.conj <= r1_conj;
            r2_side.re   <= c_rd[2*SAMPLE_W-1:SAMPLE_W];
            r2_side.im   <= c_rd[SAMPLE_W-1:0];
            r2_den       <= c_d1 * c_d2;
            r2_num       <= NUM_W'(r1_i) * NUM_W'(c_li);
        end
    end

    fbsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_vld   (r2_vld),
        .i_side  (r2_side),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .o_vld   (c_div_vld),
        .o_side  (c_div_side),
        .o_quot  (c_quot)
    );

    fbsd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_vld   (c_div_vld),
        .i_side  (c_div_side),
        .i_quot  (c_quot),
        .o_vld   (o_valid),
        .o_item  (o_item)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FFT bin sideband demodulator. Bins are written
// into the store, output bins are read back in every mode and compared with a
// bit-exact spectrum predictor, under random source and sink idling.
// ----------------------------------------------------------------------------
module tb_top;
    import fbsd_pkg::*;

    localparam int WD_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_in_item             i_item;
    logic                 o_valid;
    logic                 i_ready;
    t_out_item            o_item;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_wdata;

    fft_bin_sideband_demod_top u_top (.*);

    // predictor state
    logic [1:0]                 cur_mode;
    logic signed [OFF_W-1:0]    cur_off;
    logic [LEN_W-1:0]           cur_out_len;
    logic [LEN_W-1:0]           cur_in_len;
    logic [CORNER_W-1:0]        cur_f1;
    logic [CORNER_W-1:0]        cur_f2;
    logic signed [SAMPLE_W-1:0] bin_re_mem [MAX_BINS];
    logic signed [SAMPLE_W-1:0] bin_im_mem [MAX_BINS];
    bit                         bin_written [MAX_BINS];

    t_out_item spectrum_q[$];
    int        err_cnt;
    int        idle_cnt;
    int        src_idle_pct;
    int        snk_idle_pct;
    bit        snk_hold;
    bit        done;

    typedef struct {
        logic op;
        int   idx;
        int   re;
        int   im;
        bit   has_exp;
        int   exp_re;
        int   exp_im;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // j: signed input position; returns 0 if out of band
    function automatic bit bin_fetch(int j, output longint re, output longint im);
        int s;
        int half;
        int idx;
        s = cur_in_len;
        half = s / 2;
        re = 0;
        im = 0;
        if (j < -half || j >= half) return 0;
        idx = (j >= 0) ? j : j + s;
        if (idx < 0 || idx >= MAX_BINS) return 0;
        re = bin_re_mem[idx];
        im = bin_im_mem[idx];
        return 1;
    endfunction

    function automatic longint weigh(longint x, longint unsigned w);
        longint unsigned mag;
        longint unsigned q;
        mag = (x < 0) ? -x : x;
        q = (mag * w + 32768) >> 16;
        return sat16((x < 0) ? -longint'(q) : longint'(q));
    endfunction

    // which signed input position an output bin reads; -99999 if none
    function automatic int src_pos(int k);
        int l;
        int len;
        int i;
        l = cur_out_len;
        len = l / 2;
        if (cur_mode == MODE_RAW) begin
            if (k < len) return k + cur_off;
            if (k >= l - len && k < l) return k - l + cur_off;
            return -99999;
        end
        if (cur_mode == MODE_ZERO || k == 0 || k == len || k >= 2 * len) return -99999;
        i = (k > len) ? 2 * len - k : k;
        return (cur_mode == MODE_USB) ? cur_off + i : cur_off - i;
    endfunction

    function automatic bit pos_safe(int j);
        int s;
        int idx;
        s = cur_in_len;
        if (j < -(s / 2) || j >= s / 2) return 1;
        idx = (j >= 0) ? j : j + s;
        if (idx >= MAX_BINS) return 1;
        return bin_written[idx];
    endfunction

    function automatic t_out_item demod_bin(int k);
        t_out_item r;
        longint re;
        longint im;
        longint xr;
        longint xi;
        longint unsigned d1;
        longint unsigned d2;
        longint unsigned den;
        longint unsigned num;
        longint unsigned w;
        int l;
        int len;
        int i;
        bit mirror;
        l = cur_out_len;
        len = l / 2;
        re = 0;
        im = 0;
        if (cur_mode == MODE_RAW) begin
            if (k < len || (k >= l - len && k < l)) void'(bin_fetch(src_pos(k), re, im));
        end else if (cur_mode != MODE_ZERO) begin
            if (k != 0 && k != len && k < 2 * len) begin
                mirror = k > len;
                i = mirror ? 2 * len - k : k;
                if (bin_fetch(src_pos(k), xr, xi)) begin
                    d1 = longint'(cur_f1) + 256 * i;
                    d2 = longint'(cur_f2) + 256 * (len - i);
                    den = d1 * d2;
                    num = (longint'(2) * i * (len - i)) << 32;
                    w = (num + den / 2) / den;
                    re = weigh(xr, w);
                    im = weigh(xi, w);
                    if (mirror == (cur_mode == MODE_USB)) im = sat16(-im);
                end
            end
        end
        r.out_index = k[ADDR_W-1:0];
        r.out_re = re[SAMPLE_W-1:0];
        r.out_im = im[SAMPLE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (spectrum_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg r, int v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= r;
        i_cfg_wdata <= v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (r)
            REG_MODE:        cur_mode    = v[1:0];
            REG_BIN_OFFSET:  cur_off     = v[OFF_W-1:0];
            REG_OUT_LENGTH:  cur_out_len = v[LEN_W-1:0];
            REG_IN_LENGTH:   cur_in_len  = v[LEN_W-1:0];
            REG_LOW_CORNER:  cur_f1      = v[CORNER_W-1:0];
            REG_HIGH_CORNER: cur_f2      = v[CORNER_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send(logic op, int idx, int re, int im);
        t_in_item it;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        it.opcode    = op;
        it.bin_index = idx[ADDR_W-1:0];
        it.bin_re    = re[SAMPLE_W-1:0];
        it.bin_im    = im[SAMPLE_W-1:0];
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_WRITE) begin
            bin_re_mem[idx] = it.bin_re;
            bin_im_mem[idx] = it.bin_im;
            bin_written[idx] = 1'b1;
        end else begin
            spectrum_q.push_back(demod_bin(idx));
        end
    endtask

    task automatic send_read(int k);
        if (k < cur_out_len && !pos_safe(src_pos(k))) k = 0;
        if (cur_mode == MODE_RAW && k == 0 && !pos_safe(src_pos(0))) k = cur_out_len;
        if (k > 1023) k = 1023;
        if (k < cur_out_len && !pos_safe(src_pos(k))) return;
        send(OP_READ, k, $urandom, $urandom);
    endtask

    task automatic fill_store();
        for (int n = 0; n < 64; n++) send(OP_WRITE, n, $urandom, $urandom);
        for (int n = 960; n < 1024; n++) send(OP_WRITE, n, $urandom, $urandom);
    endtask

    task automatic random_phase(int n_items);
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(3) == 0)
                send(OP_WRITE, $urandom_range(1023), $urandom, $urandom);
            else if ($urandom_range(4) == 0)
                send_read($urandom_range(1023));
            else
                send_read($urandom_range(cur_out_len > 0 ? cur_out_len - 1 : 0));
        end
    endtask

    // sink
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (spectrum_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_item.out_index, -1);
            end else begin
                want = spectrum_q.pop_front();
                if (o_item.out_index !== want.out_index)
                    report_mismatch("out_index", o_item.out_index, want.out_index);
                if (o_item.out_re !== want.out_re)
                    report_mismatch("out_re", o_item.out_re, want.out_re);
                if (o_item.out_im !== want.out_im)
                    report_mismatch("out_im", o_item.out_im, want.out_im);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || snk_hold || done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        err_cnt = 0;
        idle_cnt = 0;
        done = 1'b0;
        snk_hold = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        cur_mode = MODE_USB;
        cur_off = 0;
        cur_out_len = 1024;
        cur_in_len = 1024;
        cur_f1 = 0;
        cur_f2 = 0;
        for (int n = 0; n < MAX_BINS; n++) bin_written[n] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config (USB, no corners)
        rows.push_back('{OP_WRITE, 0, 32767, -32768, 0, 0, 0});
        rows.push_back('{OP_WRITE, 1, 32767, -32768, 0, 0, 0});
        rows.push_back('{OP_WRITE, 1023, -32768, 32767, 0, 0, 0});
        rows.push_back('{OP_WRITE, 511, 12345, -54, 0, 0, 0});
        rows.push_back('{OP_WRITE, 512, 1, -1, 0, 0, 0});
        rows.push_back('{OP_READ, 0, 0, 0, 1, 0, 0});
        rows.push_back('{OP_READ, 512, 0, 0, 1, 0, 0});
        rows.push_back('{OP_READ, 1, 0, 0, 0, 0, 0});
        rows.push_back('{OP_READ, 1023, 0, 0, 0, 0, 0});
        rows.push_back('{OP_READ, 511, 0, 0, 0, 0, 0});
        rows.push_back('{OP_READ, 513, 0, 0, 0, 0, 0});
        foreach (rows[n]) begin
            r = rows[n];
            send(r.op, r.idx, r.re, r.im);
            if (r.has_exp && r.op == OP_READ) begin
                spectrum_q[$].out_re = r.exp_re[SAMPLE_W-1:0];
                spectrum_q[$].out_im = r.exp_im[SAMPLE_W-1:0];
            end
        end
        wait_drain();
        fill_store();
        wait_drain();

        // raw with extreme offsets, read past end, LSB, zero mode
        cfg_write(REG_MODE, MODE_RAW);
        cfg_write(REG_BIN_OFFSET, 1024);
        send_read(0); send_read(5); send_read(1023);
        wait_drain();
        cfg_write(REG_BIN_OFFSET, -1024);
        send_read(0); send_read(700);
        wait_drain();
        cfg_write(REG_OUT_LENGTH, 2);
        send_read(1); send_read(2); send_read(1023);
        wait_drain();
        cfg_write(REG_MODE, MODE_LSB);
        cfg_write(REG_OUT_LENGTH, 1024);
        cfg_write(REG_IN_LENGTH, 2);
        cfg_write(REG_BIN_OFFSET, 0);
        cfg_write(REG_LOW_CORNER, 262143);
        cfg_write(REG_HIGH_CORNER, 262143);
        send_read(1); send_read(600);
        wait_drain();
        cfg_write(REG_MODE, MODE_ZERO);
        send_read(7);
        wait_drain();

        // random phases across settings and idle profiles
        for (int ph = 0; ph < 6; ph++) begin
            src_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 61 : 0;
            snk_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 36 : 0;
            cfg_write(REG_MODE, $urandom_range(3));
            cfg_write(REG_BIN_OFFSET, $urandom_range(2048) - 1024);
            cfg_write(REG_OUT_LENGTH, 2 * $urandom_range(1, 512));
            cfg_write(REG_IN_LENGTH, 2 * $urandom_range(1, 512));
            cfg_write(REG_LOW_CORNER, (ph == 5) ? 0 : $urandom_range(262143));
            cfg_write(REG_HIGH_CORNER, (ph == 5) ? 0 : $urandom_range(20000));
            if (ph == 4) begin
                fork
                    begin
                        snk_hold = 1'b1;
                        repeat (300) @(posedge i_clk);
                        snk_hold = 1'b0;
                    end
                    random_phase(60);
                join
            end else begin
                random_phase(60);
            end
            wait_drain();
        end

        done = 1'b1;
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
